// ----- rtl/tth_pkg.sv -----
// Shared constants and types for the Toeplitz tuple hash.
// No dependencies; used by tth_fold and toeplitz_tuple_hash.
package tth_pkg;

   localparam int unsigned KeyWords   = 4;
   localparam int unsigned KeyBits    = 32 * KeyWords;
   localparam int unsigned TupleBits  = 96;
   localparam int unsigned HashBits   = 16;
   localparam int unsigned GroupBits  = 16;
   localparam int unsigned Groups     = TupleBits / GroupBits;
   // key bits touched by one group: GroupBits windows of HashBits, overlapping
   localparam int unsigned SliceBits  = GroupBits + HashBits - 1;
   localparam int unsigned CsrIdxBits = 8;

   typedef logic [31:0]            key_word_type;
   typedef logic [HashBits-1:0]    hash_type;
   typedef logic [GroupBits-1:0]   group_type;
   typedef logic [SliceBits-1:0]   slice_type;
   typedef logic [CsrIdxBits-1:0]  csr_idx_type;

   typedef enum logic [CsrIdxBits-1:0] {
      REG_KEY_WORD_0 = 8'd0,
      REG_KEY_WORD_1 = 8'd1,
      REG_KEY_WORD_2 = 8'd2,
      REG_KEY_WORD_3 = 8'd3
   } csr_reg_type;

   localparam key_word_type KeyWord0Rst = 32'h6d5a56da;
   localparam key_word_type KeyWord1Rst = 32'h255b0ec2;
   localparam key_word_type KeyWord2Rst = 32'h4167253d;
   localparam key_word_type KeyWord3Rst = 32'h43a38fb0;

endpackage

// ----- rtl/tth_fold.sv -----
// Folds one 16-bit group of tuple bits against its key slice into a
// 16-bit partial hash. Pure XOR network; depends on tth_pkg.
module tth_fold (
   input  tth_pkg::group_type grp,   // grp[15] is the first tuple bit of the group
   input  tth_pkg::slice_type slice, // key bits, highest index = earliest key bit
   output tth_pkg::hash_type  part
);

   tth_pkg::hash_type  terms [tth_pkg::GroupBits];
   tth_pkg::group_type col   [tth_pkg::HashBits];

   // tuple bit j of the group selects the window slice[30-j : 15-j]
   always_comb begin
      for (int j = 0; j < tth_pkg::GroupBits; j++) begin
         terms[j] = slice[tth_pkg::SliceBits-1-j -: tth_pkg::HashBits]
                    & {tth_pkg::HashBits{grp[tth_pkg::GroupBits-1-j]}};
      end
   end

   always_comb begin
      for (int b = 0; b < tth_pkg::HashBits; b++) begin
         for (int j = 0; j < tth_pkg::GroupBits; j++) begin
            col[b][j] = terms[j][b];
         end
      end
   end

   always_comb begin
      for (int b = 0; b < tth_pkg::HashBits; b++) begin
         part[b] = ^col[b];
      end
   end

endmodule

// ----- rtl/toeplitz_tuple_hash.sv -----
// Toeplitz receive-side hash of an IPv4 4-tuple, low 16 bits out.
// Throughput: one item per cycle.
// Stages: input register, six 16-bit group folds, final 6-way XOR.
// busy never rises; the result strobe cannot be held off and needs no hold.
// Synchronous reset clears the pipeline valids and loads the default key.
// Depends on tth_pkg and tth_fold.
module toeplitz_tuple_hash (
   input  logic                       clock,
   input  logic                       reset,

   input  logic                       start,
   output logic                       busy,
   input  logic [31:0]                req_src_addr,
   input  logic [31:0]                req_dst_addr,
   input  logic [15:0]                req_src_port,
   input  logic [15:0]                req_dst_port,

   output logic                       rsp_strobe,
   output logic [15:0]                rsp_flow_hash,

   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  tth_pkg::csr_idx_type       csr_index,
   input  logic [31:0]                csr_wdata
);

   tth_pkg::key_word_type key_ff [tth_pkg::KeyWords];
   logic [tth_pkg::KeyBits-1:0]   key_all;

   logic                          valid_s1_ff;
   logic [tth_pkg::TupleBits-1:0] tuple_s1_ff;
   logic                          valid_s2_ff;
   tth_pkg::hash_type             part_s2_ff [tth_pkg::Groups];
   tth_pkg::hash_type             part_s2_in [tth_pkg::Groups];
   logic                          strobe_s3_ff;
   tth_pkg::hash_type             hash_s3_ff;
   tth_pkg::hash_type             hash_s3_in;
   logic                          accept;
   logic                          csr_wr;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign accept    = start && !busy;
   assign csr_wr    = csr_valid && csr_ready;

   // ---- key registers ----
   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff[0] <= tth_pkg::KeyWord0Rst;
         key_ff[1] <= tth_pkg::KeyWord1Rst;
         key_ff[2] <= tth_pkg::KeyWord2Rst;
         key_ff[3] <= tth_pkg::KeyWord3Rst;
      end else if (csr_wr) begin
         case (csr_index)
            tth_pkg::REG_KEY_WORD_0: key_ff[0] <= csr_wdata;
            tth_pkg::REG_KEY_WORD_1: key_ff[1] <= csr_wdata;
            tth_pkg::REG_KEY_WORD_2: key_ff[2] <= csr_wdata;
            tth_pkg::REG_KEY_WORD_3: key_ff[3] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // key bit 0 lands in key_all[127]
   assign key_all = {key_ff[0], key_ff[1], key_ff[2], key_ff[3]};

   // ---- stage 1: capture tuple, first wire bit at the top ----
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_s1_ff <= 1'b0;
      end else begin
         valid_s1_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         tuple_s1_ff <= {req_src_addr, req_dst_addr, req_src_port, req_dst_port};
      end
   end

   // ---- stage 2: group folds ----
   // group g covers tuple bits 16g..16g+15; their low-16 windows span
   // key bits 16g+16 .. 16g+46, i.e. key_all[111-16g -: 31]
   for (genvar g = 0; g < tth_pkg::Groups; g++) begin : g_fold
      tth_fold u_fold (
         .grp   (tuple_s1_ff[tth_pkg::TupleBits-1-g*tth_pkg::GroupBits
                             -: tth_pkg::GroupBits]),
         .slice (key_all[tth_pkg::KeyBits-1-tth_pkg::HashBits-g*tth_pkg::GroupBits
                         -: tth_pkg::SliceBits]),
         .part  (part_s2_in[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_s2_ff <= 1'b0;
      end else begin
         valid_s2_ff <= valid_s1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (valid_s1_ff) begin
         part_s2_ff <= part_s2_in;
      end
   end

   // ---- stage 3: combine partials ----
   always_comb begin
      hash_s3_in = '0;
      for (int g = 0; g < tth_pkg::Groups; g++) begin
         hash_s3_in = hash_s3_in ^ part_s2_ff[g];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_s3_ff <= 1'b0;
      end else begin
         strobe_s3_ff <= valid_s2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (valid_s2_ff) begin
         hash_s3_ff <= hash_s3_in;
      end
   end

   assign rsp_strobe    = strobe_s3_ff;
   assign rsp_flow_hash = hash_s3_ff;

   // ---- assertions ----
   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##3 rsp_strobe)
      else $error("accepted item did not produce a result after 3 cycles");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(valid_s1_ff, 2))
      else $error("result strobe without a matching stage-1 item");

   a_zero_tuple: assert property (@(posedge clock) disable iff (reset)
      (valid_s1_ff && tuple_s1_ff == '0 && !csr_wr) |=> ##1 (hash_s3_ff == '0))
      else $error("all-zero tuple gave nonzero hash");

   a_bad_index: assert property (@(posedge clock) disable iff (reset)
      (csr_wr && csr_index != tth_pkg::REG_KEY_WORD_0
              && csr_index != tth_pkg::REG_KEY_WORD_1
              && csr_index != tth_pkg::REG_KEY_WORD_2
              && csr_index != tth_pkg::REG_KEY_WORD_3)
      |=> (key_all == $past(key_all)))
      else $error("write to unknown register changed the key");

endmodule

// ----- tb/sv/toeplitz_tuple_hash_tb.sv -----
// Self-checking testbench for toeplitz_tuple_hash: random and corner-case flow tuples
// under several hash keys, each result checked against a local Toeplitz hash model.
// Depends on tth_pkg and the toeplitz_tuple_hash RTL.
module toeplitz_tuple_hash_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import tth_pkg::*;

   localparam int unsigned RandomPerPhase = 235;
   localparam int unsigned Phases         = 7;
   localparam int unsigned DrainCycles    = 8;
   localparam int unsigned CycleLimit     = 500000;
   localparam int unsigned MaxPrinted     = 40;
   localparam csr_idx_type FirstBadIdx    = csr_idx_type'(KeyWords);
   localparam csr_idx_type LastBadIdx     = '1;

   typedef struct packed {
      logic [31:0] src_addr;
      logic [31:0] dst_addr;
      logic [15:0] src_port;
      logic [15:0] dst_port;
   } flow_tuple_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         start = 1'b0;
   logic         busy;
   logic [31:0]  req_src_addr = '0;
   logic [31:0]  req_dst_addr = '0;
   logic [15:0]  req_src_port = '0;
   logic [15:0]  req_dst_port = '0;
   logic         rsp_strobe;
   logic [15:0]  rsp_flow_hash;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   csr_idx_type  csr_index = '0;
   logic [31:0]  csr_wdata = '0;

   key_word_type   key_model [KeyWords];
   flow_tuple_type flow_queue [$];
   hash_type       hash_due [$];
   hash_type       want_hash;
   int unsigned    gap_left = 0;
   bit             burst_mode = 1'b0;
   int unsigned    cycles = 0;
   int unsigned    errors = 0;
   int unsigned    flows_sent = 0;
   int unsigned    hashes_checked = 0;

   toeplitz_tuple_hash i_dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_src_addr  (req_src_addr),
      .req_dst_addr  (req_dst_addr),
      .req_src_port  (req_src_port),
      .req_dst_port  (req_dst_port),
      .rsp_strobe    (rsp_strobe),
      .rsp_flow_hash (rsp_flow_hash),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   always #1 clock = ~clock;

   // Toeplitz hash: tuple bit i (from the top) selects the 32-bit key window
   // starting at key bit i; key bit 0 is the top bit of key word 0.
   function automatic hash_type rss_hash16(flow_tuple_type flow);
      logic [KeyBits-1:0]  key_bits;
      logic [TupleBits-1:0] tuple;
      logic [31:0]          acc;
      key_bits = {key_model[0], key_model[1], key_model[2], key_model[3]};
      tuple    = flow;
      acc      = '0;
      for (int i = 0; i < TupleBits; i++) begin
         if (tuple[TupleBits-1-i])
            acc ^= key_bits[KeyBits-1-i -: 32];
      end
      return acc[HashBits-1:0];
   endfunction

   task automatic report_mismatch(string msg);
      errors++;
      if (errors <= MaxPrinted)
         $display("[cycle %0d] mismatch: %s", cycles, msg);
      if (errors == MaxPrinted)
         $display("further mismatches counted but not printed");
   endtask

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (burst_mode || r < 55)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   function automatic flow_tuple_type make_flow();
      flow_tuple_type f;
      int unsigned    kind;
      kind = $urandom_range(0, 9);
      f = {$urandom(), $urandom(), $urandom()};
      case (kind)
         0: begin
            f = '0;
            f[$urandom_range(0, TupleBits-1)] = 1'b1;
         end
         1: begin
            f = '1;
            f[$urandom_range(0, TupleBits-1)] = 1'b0;
         end
         2: begin
            // private-net addresses, well-known destination port
            f.src_addr[31:16] = 16'hc0a8;
            f.dst_addr[31:24] = 8'h0a;
            f.dst_port        = 16'($urandom_range(0, 1023));
         end
         3: begin
            f.src_port = '0;
            f.dst_port = '1;
         end
         default: begin
         end
      endcase
      return f;
   endfunction

   task automatic add_flow(logic [31:0] sa, logic [31:0] da, logic [15:0] sp, logic [15:0] dp);
      flow_queue.push_back('{sa, da, sp, dp});
   endtask

   // driver: one item per handshake, random gaps between items
   always @(posedge clock) begin
      if (reset) begin
         start    <= 1'b0;
         gap_left <= 0;
      end else begin
         if (start && busy === 1'b0) begin
            hash_due.push_back(rss_hash16({req_src_addr, req_dst_addr,
                                           req_src_port, req_dst_port}));
            flows_sent++;
         end
         if (start && busy !== 1'b0) begin
            // held off, keep the item on the ports
         end else if (gap_left != 0) begin
            start    <= 1'b0;
            gap_left <= gap_left - 1;
         end else if (flow_queue.size() != 0) begin
            flow_tuple_type f;
            f = flow_queue.pop_front();
            req_src_addr <= f.src_addr;
            req_dst_addr <= f.dst_addr;
            req_src_port <= f.src_port;
            req_dst_port <= f.dst_port;
            start        <= 1'b1;
            gap_left     <= pick_gap();
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor: results come as one-cycle strobes
   always @(posedge clock) begin
      if (!reset && rsp_strobe === 1'b1) begin
         if (hash_due.size() == 0) begin
            report_mismatch($sformatf("hash %h with no flow outstanding", rsp_flow_hash));
         end else begin
            want_hash = hash_due.pop_front();
            hashes_checked++;
            if (rsp_flow_hash !== want_hash)
               report_mismatch($sformatf("flow_hash %h, expected %h", rsp_flow_hash,
                                         want_hash));
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CycleLimit) begin
         $display("timeout after %0d cycles", cycles);
         $display("CHECK FAILED");
         $finish;
      end
   end

   // call at a rising edge; leaves csr_valid high for a following write
   task automatic csr_write(csr_idx_type idx, key_word_type data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (csr_ready !== 1'b1);
      if (idx < KeyWords)
         key_model[idx] = data;
   endtask

   task automatic load_key(key_word_type k0, key_word_type k1, key_word_type k2,
                           key_word_type k3);
      @(posedge clock);
      csr_write(REG_KEY_WORD_0, k0);
      csr_write(REG_KEY_WORD_1, k1);
      // out-of-range index must leave the key alone
      csr_write(csr_idx_type'($urandom_range(FirstBadIdx, LastBadIdx)), $urandom());
      csr_write(REG_KEY_WORD_2, k2);
      csr_write(REG_KEY_WORD_3, k3);
      csr_write(LastBadIdx, $urandom());
      csr_valid <= 1'b0;
   endtask

   task automatic wait_idle();
      do @(posedge clock);
      while (flow_queue.size() != 0 || start || hash_due.size() != 0);
      repeat (DrainCycles) @(posedge clock);
   endtask

   initial begin
      key_model[0] = KeyWord0Rst;
      key_model[1] = KeyWord1Rst;
      key_model[2] = KeyWord2Rst;
      key_model[3] = KeyWord3Rst;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      for (int p = 0; p < Phases; p++) begin
         case (p)
            0: begin
               // reset key; corner tuples first
               add_flow('0, '0, '0, '0);
               add_flow('1, '1, '1, '1);
               add_flow('1, '0, '0, '0);
               add_flow('0, '1, '0, '0);
               add_flow('0, '0, '1, '0);
               add_flow('0, '0, '0, '1);
               add_flow(32'h8000_0000, '0, '0, '0);
               add_flow('0, '0, '0, 16'h0001);
               add_flow(32'h0000_0001, 32'h8000_0000, '0, '0);
               add_flow('0, 32'h0000_0001, 16'h8000, '0);
               add_flow('0, '0, 16'h0001, 16'h8000);
               add_flow(32'haaaa_aaaa, 32'h5555_5555, 16'haaaa, 16'h5555);
               add_flow(32'h5555_5555, 32'haaaa_aaaa, 16'h5555, 16'haaaa);
               add_flow(32'h420f_0201, 32'ha1a2_a3a4, 16'd2794, 16'd1766);
               add_flow(32'hc0a8_0101, 32'h0a00_0001, 16'd80, 16'd443);
               add_flow(32'h7fff_ffff, 32'hffff_fffe, 16'h7fff, 16'hfffe);
               add_flow('1, '1, '1, '0);
               add_flow('0, '0, '0, '0);
            end
            1: load_key('1, '1, '1, '1);
            2: load_key('0, '0, '0, '0);
            3: load_key(32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555);
            // reset key with the last key bit flipped: hash must not change
            4: load_key(KeyWord0Rst, KeyWord1Rst, KeyWord2Rst, KeyWord3Rst ^ 32'h1);
            default: load_key($urandom(), $urandom(), $urandom(), $urandom());
         endcase
         burst_mode = (p == 2) || ($urandom_range(0, 3) == 0);
         for (int n = 0; n < RandomPerPhase; n++)
            flow_queue.push_back(make_flow());
         wait_idle();
      end

      if (hash_due.size() != 0)
         report_mismatch($sformatf("%0d hashes never came out", hash_due.size()));
      $display("%0d flow tuples hashed under %0d key settings, %0d hashes compared",
               flows_sent, Phases, hashes_checked);
      if (errors == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

// ----- files.f -----
rtl/tth_pkg.sv
rtl/tth_fold.sv
rtl/toeplitz_tuple_hash.sv
tb/sv/toeplitz_tuple_hash_tb.sv
